// ===== rtl/cssd_pkg.sv =====
// Shared constants, binomial table, and controller/datapath interface types.
package cssd_pkg;

  localparam int MaxChannels = 6;
  localparam int FracBits    = 31;

  // Fixed field widths of the stream payloads and the config register
  localparam int RateW      = 24;
  localparam int CfgW       = 3;
  localparam int IdxFieldW  = 3;
  localparam int ProbFieldW = 32;
  localparam int InDataW    = 4 * RateW;
  localparam int OutBits    = 2 * IdxFieldW + 2 * ProbFieldW;
  localparam int OutDataW   = ((OutBits + 7) / 8) * 8;
  localparam int UserW      = 2;

  localparam int Depth  = MaxChannels + 1;
  localparam int CntW   = $clog2(MaxChannels + 1);
  localparam int ProbW  = FracBits + 1;
  localparam int NumW   = 2 * RateW;
  localparam int DenW   = NumW + 2;
  localparam int RemW   = DenW + 1;
  localparam int MulW   = 32;
  localparam int ProdW  = 2 * MulW;
  localparam int BinW   = MaxChannels;
  localparam int CoefW  = 2 * BinW;
  localparam int StepW  = $clog2(FracBits);

  localparam logic [ProbW-1:0] OneQ = {1'b1, {FracBits{1'b0}}};

  // Probability selector codes
  localparam logic [1:0] SelP1 = 2'd0;
  localparam logic [1:0] SelP2 = 2'd1;
  localparam logic [1:0] SelP3 = 2'd2;

  typedef logic [Depth-1:0][Depth-1:0][BinW-1:0] bin_tab_t;

  // Pascal triangle, built at elaboration
  function automatic bin_tab_t pascal_table();
    bin_tab_t c;
    c = '0;
    for (int n = 0; n < Depth; n++) begin
      c[n][0] = BinW'(1);
      for (int j = 1; j <= n; j++) begin
        c[n][j] = BinW'(c[n-1][j-1] + c[n-1][j]);
      end
    end
    return c;
  endfunction

  localparam bin_tab_t BinTab = pascal_table();

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_N1,
    OP_N2,
    OP_N3,
    OP_DEN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_P_STORE,
    OP_POW,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [1:0]      sel;
    logic [CntW-1:0] pidx;
    logic [CntW-1:0] k;
    logic [CntW-1:0] l;
    logic [CntW-1:0] ch;
    logic            level_done;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/cssd_ctrl.sv =====
// Sequencer: config register, run indices and the command stream to the datapath.
module cssd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cssd_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cssd_pkg::sts_t            sts_i,
  output cssd_pkg::cmd_t            cmd_o
);
  import cssd_pkg::*;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StN1      = 4'd1;
  localparam logic [3:0] StN2      = 4'd2;
  localparam logic [3:0] StN3      = 4'd3;
  localparam logic [3:0] StDen     = 4'd4;
  localparam logic [3:0] StDivInit = 4'd5;
  localparam logic [3:0] StDivStep = 4'd6;
  localparam logic [3:0] StPStore  = 4'd7;
  localparam logic [3:0] StPow     = 4'd8;
  localparam logic [3:0] StT1      = 4'd9;
  localparam logic [3:0] StT2      = 4'd10;
  localparam logic [3:0] StT3      = 4'd11;
  localparam logic [3:0] StEmit    = 4'd12;

  logic [3:0]       state_q, state_d;
  logic [CfgW-1:0]  cfg_q;
  logic [CntW-1:0]  ch_q, ch_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  l_q, l_d;
  logic [CntW-1:0]  pidx_q, pidx_d;
  logic [1:0]       sel_q, sel_d;
  logic [StepW-1:0] step_q, step_d;
  logic             lvl_done;
  logic             run_last;

  assign lvl_done = (l_q == k_q);
  assign run_last = lvl_done && (k_q == ch_q);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    k_d     = k_q;
    l_d     = l_q;
    pidx_d  = pidx_q;
    sel_d   = sel_q;
    step_d  = step_q;

    cmd_o.op         = OP_NONE;
    cmd_o.sel        = sel_q;
    cmd_o.pidx       = pidx_q;
    cmd_o.k          = k_q;
    cmd_o.l          = l_q;
    cmd_o.ch         = ch_q;
    cmd_o.level_done = lvl_done;
    cmd_o.last       = run_last;

    in_ready_o = (state_q == StIdle);

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (int'(cfg_q) > MaxChannels) begin
            ch_d = CntW'(MaxChannels);
          end else begin
            ch_d = CntW'(cfg_q);
          end
          state_d = StN1;
        end
      end
      StN1: begin
        cmd_o.op = OP_N1;
        state_d  = StN2;
      end
      StN2: begin
        cmd_o.op = OP_N2;
        state_d  = StN3;
      end
      StN3: begin
        cmd_o.op = OP_N3;
        state_d  = StDen;
      end
      StDen: begin
        cmd_o.op = OP_DEN;
        sel_d    = SelP1;
        k_d      = '0;
        l_d      = '0;
        state_d  = StDivInit;
      end
      StDivInit: begin
        // zero denominator: every term is forced to zero, skip the math
        if (sts_i.bad) begin
          state_d = StT1;
        end else begin
          cmd_o.op = OP_DIV_INIT;
          step_d   = '0;
          state_d  = StDivStep;
        end
      end
      StDivStep: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == StepW'(FracBits - 1)) begin
          state_d = StPStore;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      StPStore: begin
        cmd_o.op = OP_P_STORE;
        if (sel_q == SelP3) begin
          sel_d  = SelP1;
          pidx_d = CntW'(2);
          if (MaxChannels < 2) begin
            state_d = StT1;
          end else begin
            state_d = StPow;
          end
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = StDivInit;
        end
      end
      StPow: begin
        cmd_o.op = OP_POW;
        if (pidx_q == CntW'(MaxChannels)) begin
          pidx_d = CntW'(2);
          if (sel_q == SelP3) begin
            state_d = StT1;
          end else begin
            sel_d = sel_q + 2'd1;
          end
        end else begin
          pidx_d = pidx_q + CntW'(1);
        end
      end
      StT1: begin
        cmd_o.op = OP_T1;
        state_d  = StT2;
      end
      StT2: begin
        cmd_o.op = OP_T2;
        state_d  = StT3;
      end
      StT3: begin
        cmd_o.op = OP_T3;
        state_d  = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (lvl_done) begin
            if (run_last) begin
              state_d = StIdle;
            end else begin
              k_d     = k_q + CntW'(1);
              l_d     = '0;
              state_d = StT1;
            end
          end else begin
            l_d     = l_q + CntW'(1);
            state_d = StT1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cfg_q   <= CfgW'(1);
      ch_q    <= '0;
      k_q     <= '0;
      l_q     <= '0;
      pidx_q  <= '0;
      sel_q   <= SelP1;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      k_q     <= k_d;
      l_q     <= l_d;
      pidx_q  <= pidx_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== rtl/cssd_dp.sv =====
// Datapath: shared multiplier, radix-2 divider, power tables and output register.
module cssd_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cssd_pkg::cmd_t                  cmd_i,
  input  logic [cssd_pkg::RateW-1:0]      rate_1_to_2_i,
  input  logic [cssd_pkg::RateW-1:0]      rate_2_to_1_i,
  input  logic [cssd_pkg::RateW-1:0]      rate_2_to_3_i,
  input  logic [cssd_pkg::RateW-1:0]      rate_3_to_2_i,
  output cssd_pkg::sts_t                  sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [cssd_pkg::IdxFieldW-1:0]  level_index_o,
  output logic [cssd_pkg::IdxFieldW-1:0]  inner_index_o,
  output logic [cssd_pkg::ProbFieldW-1:0] joint_prob_o,
  output logic [cssd_pkg::ProbFieldW-1:0] level_prob_o,
  output logic                            level_done_o,
  output logic                            last_o,
  output logic                            bad_rates_o
);
  import cssd_pkg::*;

  logic [RateW-1:0] r12_q, r21_q, r23_q, r32_q;
  logic [NumW-1:0]  n1_q, n2_q, n3_q;
  logic [DenW-1:0]  den_q, den_sum;
  logic             bad_q;
  logic [RemW-1:0]  rem_q;
  logic [ProbW-1:0] quo_q;
  logic [ProbW-1:0] pw_q [3][Depth];
  logic [CntW-1:0]  rd_idx [3];
  logic [ProbW-1:0] rd_pw [3];
  logic [ProbW-1:0] t_q, term_q, sum_q;
  logic [CoefW-1:0] coef_q;

  logic [CntW-1:0]  pm1, kml, chmk;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;
  logic [ProbW-1:0] qprod, term_sat;

  logic [NumW-1:0]  num_sel;
  logic [RemW-1:0]  num_ext, den_ext, rem_sh;
  logic             ge_init, ge_step;

  logic [ProbW:0]   sum_add;
  logic [ProbW-1:0] sum_sat;

  logic                  out_valid_q;
  logic [IdxFieldW-1:0]  lvl_idx_q, inn_idx_q;
  logic [ProbFieldW-1:0] joint_q, lvl_prob_q;
  logic                  lvl_done_q, last_q, bad_out_q;

  assign pm1  = cmd_i.pidx - CntW'(1);
  assign kml  = cmd_i.k - cmd_i.l;
  assign chmk = cmd_i.ch - cmd_i.k;

  // one read port per power table
  always_comb begin
    if (cmd_i.op == OP_POW) begin
      rd_idx[0] = pm1;
      rd_idx[1] = pm1;
      rd_idx[2] = pm1;
    end else begin
      rd_idx[0] = cmd_i.l;
      rd_idx[1] = kml;
      rd_idx[2] = chmk;
    end
    for (int s = 0; s < 3; s++) begin
      rd_pw[s] = pw_q[s][rd_idx[s]];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_N1: begin
        mul_a = MulW'(r21_q);
        mul_b = MulW'(r32_q);
      end
      OP_N2: begin
        mul_a = MulW'(r12_q);
        mul_b = MulW'(r23_q);
      end
      OP_N3: begin
        mul_a = MulW'(r12_q);
        mul_b = MulW'(r32_q);
      end
      OP_POW: begin
        mul_a = MulW'(rd_pw[cmd_i.sel]);
        mul_b = MulW'(pw_q[cmd_i.sel][1]);
      end
      OP_T1: begin
        mul_a = MulW'(rd_pw[0]);
        mul_b = MulW'(rd_pw[1]);
      end
      OP_T2: begin
        mul_a = MulW'(t_q);
        mul_b = MulW'(rd_pw[2]);
      end
      OP_T3: begin
        mul_a = MulW'(coef_q);
        mul_b = MulW'(t_q);
      end
      default: ;
    endcase
  end

  assign prod     = ProdW'(mul_a) * ProdW'(mul_b);
  assign qprod    = ProbW'(prod >> FracBits);
  assign term_sat = (prod > ProdW'(OneQ)) ? OneQ : ProbW'(prod);

  assign den_sum = DenW'(n1_q) + DenW'(n2_q) + DenW'(n3_q);

  // restoring divider, one quotient bit per cycle
  always_comb begin
    unique case (cmd_i.sel)
      SelP1:   num_sel = n1_q;
      SelP2:   num_sel = n2_q;
      default: num_sel = n3_q;
    endcase
  end

  assign num_ext = RemW'(num_sel);
  assign den_ext = RemW'(den_q);
  assign rem_sh  = {rem_q[RemW-2:0], 1'b0};
  assign ge_init = (num_ext >= den_ext);
  assign ge_step = (rem_sh >= den_ext);

  assign sum_add = (ProbW+1)'(sum_q) + (ProbW+1)'(term_q);
  assign sum_sat = (sum_add > (ProbW+1)'(OneQ)) ? OneQ : ProbW'(sum_add);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        r12_q <= rate_1_to_2_i;
        r21_q <= rate_2_to_1_i;
        r23_q <= rate_2_to_3_i;
        r32_q <= rate_3_to_2_i;
        sum_q <= '0;
      end
      OP_N1: n1_q <= NumW'(prod);
      OP_N2: n2_q <= NumW'(prod);
      OP_N3: n3_q <= NumW'(prod);
      OP_DEN: begin
        den_q <= den_sum;
        bad_q <= (den_sum == '0);
      end
      OP_DIV_INIT: begin
        rem_q <= ge_init ? (num_ext - den_ext) : num_ext;
        quo_q <= ProbW'(ge_init);
      end
      OP_DIV_STEP: begin
        rem_q <= ge_step ? (rem_sh - den_ext) : rem_sh;
        quo_q <= {quo_q[ProbW-2:0], ge_step};
      end
      OP_P_STORE: begin
        pw_q[cmd_i.sel][0] <= OneQ;
        pw_q[cmd_i.sel][1] <= quo_q;
      end
      OP_POW: pw_q[cmd_i.sel][cmd_i.pidx] <= qprod;
      OP_T1: begin
        t_q    <= qprod;
        coef_q <= CoefW'(BinTab[cmd_i.ch][cmd_i.k]) * CoefW'(BinTab[cmd_i.k][cmd_i.l]);
      end
      OP_T2: t_q <= qprod;
      OP_T3: term_q <= bad_q ? '0 : term_sat;
      OP_EMIT: begin
        sum_q      <= cmd_i.level_done ? '0 : sum_sat;
        lvl_idx_q  <= IdxFieldW'(cmd_i.k);
        inn_idx_q  <= IdxFieldW'(cmd_i.l);
        joint_q    <= ProbFieldW'(term_q);
        lvl_prob_q <= cmd_i.level_done ? ProbFieldW'(sum_sat) : '0;
        lvl_done_q <= cmd_i.level_done;
        last_q     <= cmd_i.last;
        bad_out_q  <= bad_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.bad      = bad_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign level_index_o = lvl_idx_q;
  assign inner_index_o = inn_idx_q;
  assign joint_prob_o  = joint_q;
  assign level_prob_o  = lvl_prob_q;
  assign level_done_o  = lvl_done_q;
  assign last_o        = last_q;
  assign bad_rates_o   = bad_out_q;

endmodule

// ===== rtl/channel_steady_state_distribution.sv =====
// Top level: steady-state multinomial occupancy of a patch of three-state channels.
//
//   channel   dir  payload                                          handshake
//   s_axis    in   tdata: r12, r21, r23, r32 (24b each)             tvalid/tready
//   m_axis    out  tdata: k, l, joint, level sum; tuser; tlast      tvalid/tready
//   cfg       in   cfg_wdata_i: channel_count (3b)                  cfg_we_i, no wait
//
// One input transfer at a time. For N = min(channel_count, 6) an item gives
// T = (N+1)(N+2)/2 result transfers. The three 32-step divisions feed the power
// tables, then each term runs T1, T2 and T3 on the single shared 32x32 multiplier
// and then EMIT, which waits while the output register is full and m_axis_tready is low.
// With a zero denominator the divisions and the power steps are skipped.
// Reset clears the sequencer and the output valid; channel_count resets to 1.
// A stalled result sits in the output register while the next term is computed.
module channel_steady_state_distribution (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [cssd_pkg::CfgW-1:0]        cfg_wdata_i,
  // rate input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [23:0] rate_1_to_2, [47:24] rate_2_to_1, [71:48] rate_2_to_3, [95:72] rate_3_to_2
  input  logic [cssd_pkg::InDataW-1:0]     s_axis_tdata,
  // term output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] level_index, [5:3] inner_index, [37:6] joint_prob, [69:38] level_prob, zero pad
  output logic [cssd_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] level_done, [1] bad_rates
  output logic [cssd_pkg::UserW-1:0]       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import cssd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [IdxFieldW-1:0]  level_index;
  logic [IdxFieldW-1:0]  inner_index;
  logic [ProbFieldW-1:0] joint_prob;
  logic [ProbFieldW-1:0] level_prob;
  logic                  level_done;
  logic                  last;
  logic                  bad_rates;

  // Sequencer: owns channel_count and the k/l/power/divider indices
  cssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: rates are captured on the accepting edge (op LOAD)
  cssd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rate_1_to_2_i (s_axis_tdata[RateW-1:0]),
    .rate_2_to_1_i (s_axis_tdata[2*RateW-1:RateW]),
    .rate_2_to_3_i (s_axis_tdata[3*RateW-1:2*RateW]),
    .rate_3_to_2_i (s_axis_tdata[4*RateW-1:3*RateW]),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .level_index_o (level_index),
    .inner_index_o (inner_index),
    .joint_prob_o  (joint_prob),
    .level_prob_o  (level_prob),
    .level_done_o  (level_done),
    .last_o        (last),
    .bad_rates_o   (bad_rates)
  );

  // Pack the result fields, first field in the low bits
  assign m_axis_tdata = {{(OutDataW - OutBits){1'b0}},
                         level_prob, joint_prob, inner_index, level_index};
  assign m_axis_tuser = {bad_rates, level_done};
  assign m_axis_tlast = last;

endmodule

// ===== bench/tb_channel_steady_state_distribution.sv =====
// Self-checking bench for the three-state channel occupancy block: directed and random rates.
module tb_channel_steady_state_distribution;
  timeunit 1ns;
  timeprecision 1ps;

  import cssd_pkg::*;

  // idle percentage per side, stall budget before the run is declared hung
  localparam int IdlePct    = 26;
  localparam int HangCycles = 5000;
  localparam int RandomGoal = 136;

  localparam logic [ProbFieldW-1:0] ProbOne = ProbFieldW'(OneQ);

  typedef struct packed {
    logic [RateW-1:0] r12;
    logic [RateW-1:0] r21;
    logic [RateW-1:0] r23;
    logic [RateW-1:0] r32;
  } rate_set_t;

  typedef struct packed {
    logic [IdxFieldW-1:0]  level_index;
    logic [IdxFieldW-1:0]  inner_index;
    logic [ProbFieldW-1:0] joint_prob;
    logic [ProbFieldW-1:0] level_prob;
    logic                  level_done;
    logic                  last;
    logic                  bad_rates;
  } occupancy_term_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgW-1:0]      cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [UserW-1:0]     m_axis_tuser;
  logic                 m_axis_tlast;

  occupancy_term_t pending_terms[$];   // predicted terms, oldest first
  logic [CfgW-1:0] channel_count_q;    // bench copy of the count register
  int              mismatch_count;
  int              items_sent;
  bit              steady_phase;       // suppresses idling on both sides
  int              quiet_cycles;

  channel_steady_state_distribution uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit idle_roll();
    return !steady_phase && ($urandom_range(0, 99) < IdlePct);
  endfunction

  // ---------------------------------------------------------------------------
  // Occupancy predictor, all probabilities unsigned with FracBits fraction bits
  // ---------------------------------------------------------------------------

  // product of two probabilities, truncated back to the fixed-point grid
  function automatic logic [ProbFieldW-1:0] trunc_mul(logic [ProbFieldW-1:0] a,
                                                      logic [ProbFieldW-1:0] b);
    logic [2*ProbFieldW-1:0] prod;
    prod = {{ProbFieldW{1'b0}}, a} * {{ProbFieldW{1'b0}}, b};
    return ProbFieldW'(prod >> FracBits);
  endfunction

  // x^n by repeated truncated multiply, starting from 1.0
  function automatic logic [ProbFieldW-1:0] prob_power(logic [ProbFieldW-1:0] x, int n);
    logic [ProbFieldW-1:0] acc;
    acc = ProbOne;
    for (int i = 0; i < n; i++) acc = trunc_mul(acc, x);
    return acc;
  endfunction

  function automatic logic [63:0] factorial(int n);
    logic [63:0] f;
    f = 64'd1;
    for (int i = 2; i <= n; i++) f = f * 64'(i);
    return f;
  endfunction

  // floor(num * 2^F / den), exact; num never exceeds den
  function automatic logic [ProbFieldW-1:0] rate_share(logic [NumW-1:0] num,
                                                       logic [DenW-1:0] den);
    logic [NumW+FracBits-1:0] scaled;
    logic [NumW+FracBits-1:0] quot;
    scaled = {num, {FracBits{1'b0}}};
    quot   = scaled / (NumW+FracBits)'(den);
    return ProbFieldW'(quot);
  endfunction

  function automatic logic [ProbFieldW-1:0] clamp_one(logic [63:0] v);
    return (v > 64'(ProbOne)) ? ProbOne : ProbFieldW'(v);
  endfunction

  // queue every term that one accepted rate set produces at the current count
  function automatic void predict_occupancy(rate_set_t r);
    logic [NumW-1:0]       n1, n2, n3;
    logic [DenW-1:0]       den;
    logic [ProbFieldW-1:0] p1, p2, p3, t, sum;
    logic [63:0]           coef;
    bit                    bad;
    int                    ch;
    occupancy_term_t       term;
    n1  = NumW'(r.r21) * NumW'(r.r32);
    n2  = NumW'(r.r12) * NumW'(r.r23);
    n3  = NumW'(r.r12) * NumW'(r.r32);
    den = DenW'(n1) + DenW'(n2) + DenW'(n3);
    bad = (den == '0);
    ch  = (int'(channel_count_q) > MaxChannels) ? MaxChannels : int'(channel_count_q);
    p1  = bad ? '0 : rate_share(n1, den);
    p2  = bad ? '0 : rate_share(n2, den);
    p3  = bad ? '0 : rate_share(n3, den);
    for (int k = 0; k <= ch; k++) begin
      sum = '0;
      for (int l = 0; l <= k; l++) begin
        term = '0;
        if (!bad) begin
          t    = trunc_mul(prob_power(p1, l), prob_power(p2, k - l));
          t    = trunc_mul(t, prob_power(p3, ch - k));
          // multinomial coefficient ch!/(l!(k-l)!(ch-k)!) applied last
          coef = factorial(ch) / (factorial(l) * factorial(k - l) * factorial(ch - k));
          term.joint_prob = clamp_one(coef * 64'(t));
        end
        sum = clamp_one(64'(sum) + 64'(term.joint_prob));
        term.level_index = IdxFieldW'(k);
        term.inner_index = IdxFieldW'(l);
        term.level_done  = (l == k);
        term.level_prob  = (l == k) ? sum : '0;
        term.last        = (l == k) && (k == ch);
        term.bad_rates   = bad;
        pending_terms.push_back(term);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t ns MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // result side: random backpressure, released for the steady stretch
  always @(posedge clk_i) m_axis_tready <= rst_ni && !idle_roll();

  // one compare per accepted result transfer; values seen are the pre-edge ones
  always @(posedge clk_i) begin
    occupancy_term_t want;
    occupancy_term_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.level_index = m_axis_tdata[2:0];
      got.inner_index = m_axis_tdata[5:3];
      got.joint_prob  = m_axis_tdata[37:6];
      got.level_prob  = m_axis_tdata[69:38];
      got.level_done  = m_axis_tuser[0];
      got.bad_rates   = m_axis_tuser[1];
      got.last        = m_axis_tlast;
      if (pending_terms.size() == 0) begin
        report_mismatch("unexpected result transfer, k/l", {got.level_index, got.inner_index},
                        0);
      end else begin
        want = pending_terms.pop_front();
        if (got.level_index !== want.level_index)
          report_mismatch("level_index", got.level_index, want.level_index);
        if (got.inner_index !== want.inner_index)
          report_mismatch("inner_index", got.inner_index, want.inner_index);
        if (got.joint_prob !== want.joint_prob)
          report_mismatch("joint_prob", got.joint_prob, want.joint_prob);
        if (got.level_prob !== want.level_prob)
          report_mismatch("level_prob", got.level_prob, want.level_prob);
        if (got.level_done !== want.level_done)
          report_mismatch("level_done", got.level_done, want.level_done);
        if (got.last !== want.last)
          report_mismatch("last", got.last, want.last);
        if (got.bad_rates !== want.bad_rates)
          report_mismatch("bad_rates", got.bad_rates, want.bad_rates);
      end
    end
  end

  // hang detector: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangCycles) begin
      $display("timeout: no transfer for %0d cycles", HangCycles);
      $display("channel_steady_state_distribution test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // one rate-set transfer; valid stays high after acceptance so back-to-back
  // items need no second assignment in the same step
  task automatic send_rates(input rate_set_t r);
    while (idle_roll()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.r32, r.r23, r.r21, r.r12};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_occupancy(r);
    items_sent++;
  endtask

  // count register is only touched once the block has drained
  task automatic write_channel_count(input logic [CfgW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
    // sequencer may still be winding down after the final result
    repeat (12) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    channel_count_q  = value;
  endtask

  function automatic logic [RateW-1:0] random_rate();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return RateW'($urandom_range(0, 3));
      4:       return RateW'(1) << $urandom_range(0, RateW - 1);
      default: return RateW'($urandom());
    endcase
  endfunction

  function automatic rate_set_t mk_rates(int a, int b, int c, int d);
    rate_set_t r;
    r.r12 = RateW'(a);
    r.r21 = RateW'(b);
    r.r23 = RateW'(c);
    r.r32 = RateW'(d);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // count left at its reset value of one channel
  task automatic test_reset_count();
    send_rates(mk_rates(1, 1, 1, 1));
    send_rates(mk_rates(100, 300, 200, 50));
  endtask

  // rate extremes at the full channel count
  task automatic test_rate_extremes();
    localparam int RMax = (1 << RateW) - 1;
    write_channel_count(CfgW'(MaxChannels));
    send_rates(mk_rates(RMax, RMax, RMax, RMax));
    send_rates(mk_rates(0, 0, 0, 0));                 // zero denominator
    send_rates(mk_rates(0, RMax, RMax, 0));           // nonzero rates, still zero denominator
    send_rates(mk_rates(0, RMax, RMax, RMax));        // all weight in state one
    send_rates(mk_rates(RMax, 0, RMax, 0));           // all weight in state two
    send_rates(mk_rates(RMax, 0, 0, RMax));           // all weight in state three
    send_rates(mk_rates(RMax, 1, 1, RMax));
    send_rates(mk_rates('hAAAAAA, 'h555555, 'h555555, 'hAAAAAA));
    send_rates(mk_rates(1, RMax, 1, RMax));
  endtask

  // no channels: a single term per item, certain unless the denominator is zero
  task automatic test_zero_channels();
    write_channel_count('0);
    send_rates(mk_rates(7, 3, 5, 11));
    send_rates(mk_rates(0, 0, 9, 0));
  endtask

  // count above the supported maximum saturates
  task automatic test_count_saturation();
    write_channel_count('1);
    send_rates(mk_rates(2, 1, 4, 3));
    send_rates(mk_rates(0, 0, 0, 0));
  endtask

  // random counts per phase, random rates, one phase without any idling
  task automatic test_random_rates();
    rate_set_t r;
    int        start;
    int        phase;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RandomGoal) begin
      write_channel_count(CfgW'($urandom_range(0, 7)));
      steady_phase = (phase == 3);
      repeat ($urandom_range(6, 16)) begin
        r.r12 = random_rate();
        r.r21 = random_rate();
        r.r23 = random_rate();
        r.r32 = random_rate();
        send_rates(r);
      end
      phase++;
    end
    steady_phase = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    channel_count_q = CfgW'(1);
    mismatch_count  = 0;
    items_sent      = 0;
    steady_phase    = 1'b0;
    quiet_cycles    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_count();
    test_rate_extremes();
    test_zero_channels();
    test_count_saturation();
    test_random_rates();

    // drain, then linger so a stray extra transfer is still caught
    s_axis_tvalid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("channel_steady_state_distribution test passed");
    end else begin
      $display("channel_steady_state_distribution test failed");
    end
    $finish;
  end

endmodule
